/* rtl/pps_pkg.sv */
package pps_pkg;

  localparam int PPS_COORD_WIDTH = 32;
  localparam int PPS_MATRIX_ENTRY_WIDTH = 16;
  // root bits resolved per isqrt pipeline stage
  localparam int PPS_SQRT_ITERS = 4;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CHAN_W = 16;
  localparam int COLOR_W = 3 * CHAN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_MODE = 3'd0,
    CFG_COLOR_FIRST  = 3'd1,
    CFG_COLOR_SECOND = 3'd2,
    CFG_MATRIX_ROW_X = 3'd3,
    CFG_MATRIX_ROW_Y = 3'd4,
    CFG_MATRIX_ROW_Z = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_STRIPE   = 2'd0,
    MODE_GRADIENT = 2'd1,
    MODE_RING     = 2'd2,
    MODE_CHECKER  = 2'd3
  } mode_t;

  localparam logic [COLOR_W-1:0] COLOR_FIRST_RST = 48'h8000_8000_8000;
  localparam logic [COLOR_W-1:0] COLOR_SECOND_RST = 48'h0;
  localparam logic [CFG_DATA_W-1:0] ROW_X_RST = 64'h0000_0000_0000_0100;
  localparam logic [CFG_DATA_W-1:0] ROW_Y_RST = 64'h0000_0000_0100_0000;
  localparam logic [CFG_DATA_W-1:0] ROW_Z_RST = 64'h0000_0100_0000_0000;

  // per-item results that ride alongside the ring datapath
  typedef struct packed {
    logic [COLOR_W-1:0] grad;
    logic               stripe_odd;
    logic               checker_odd;
  } side_t;

endpackage

/* rtl/procedural_pattern_shader_core.sv */
// pipeline: affine product and sum stages, stage 3, stages 4 and 5, isqrt stages, output register
// throughput: one point per cycle while the output is not stalled; the isqrt pipeline resolves 4 root bits a stage
// a stall at the output freezes every stage at once
// synchronous active-low reset clears valids and restores identity matrix,
// mid-grey first colour, black second colour and stripe mode
module procedural_pattern_shader_core
  import pps_pkg::*;
#(
  parameter int COORD_WIDTH = PPS_COORD_WIDTH,
  parameter int MATRIX_ENTRY_WIDTH = PPS_MATRIX_ENTRY_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    in_point_x,
  input  logic signed [31:0]    in_point_y,
  input  logic signed [31:0]    in_point_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAN_W-1:0]     out_red,
  output logic [CHAN_W-1:0]     out_green,
  output logic [CHAN_W-1:0]     out_blue,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int PB = (CW > 16) ? 16 : CW - 1;
  localparam int H = (CW + 1) / 2;
  localparam int HW = CW - H;
  localparam int DW = (2 * CW > 34) ? 2 * CW - 32 : 2;
  localparam int SPW = DW + 32;
  localparam int RW = DW / 2;
  localparam int NST = (RW + PPS_SQRT_ITERS - 1) / PPS_SQRT_ITERS;

  mode_t               mode_r;
  logic [COLOR_W-1:0]  col_a_r;
  logic [COLOR_W-1:0]  col_b_r;
  logic [CFG_DATA_W-1:0] row_x_r;
  logic [CFG_DATA_W-1:0] row_y_r;
  logic [CFG_DATA_W-1:0] row_z_r;

  logic en;
  logic out_valid_r;
  logic [COLOR_W-1:0] out_col_r;

  logic                 v2;
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic signed [CW-1:0] pz;

  logic [2*H-1:0]  llx_r, llz_r;
  logic [CW-1:0]   lhx_r, lhz_r;
  logic [2*HW-1:0] hhx_r, hhz_r;
  side_t           side3_nxt;
  side_t           side3_r;
  logic            v3_r;

  logic [SPW-1:0] sqx_r, sqz_r;
  logic           v4_r;
  logic [DW-1:0]  d5_r;
  logic           v5_r;
  side_t          side_r [NST+2];

  logic sq_vld;
  logic sq_odd;
  logic odd;
  logic [COLOR_W-1:0] col_nxt;

  assign en = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STRIPE;
      col_a_r <= COLOR_FIRST_RST;
      col_b_r <= COLOR_SECOND_RST;
      row_x_r <= ROW_X_RST;
      row_y_r <= ROW_Y_RST;
      row_z_r <= ROW_Z_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PATTERN_MODE: mode_r <= mode_t'(cfg_data[1:0]);
        CFG_COLOR_FIRST:  col_a_r <= cfg_data[COLOR_W-1:0];
        CFG_COLOR_SECOND: col_b_r <= cfg_data[COLOR_W-1:0];
        CFG_MATRIX_ROW_X: row_x_r <= cfg_data;
        CFG_MATRIX_ROW_Y: row_y_r <= cfg_data;
        CFG_MATRIX_ROW_Z: row_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  pps_affine #(
    .COORD_WIDTH(COORD_WIDTH),
    .MATRIX_ENTRY_WIDTH(MATRIX_ENTRY_WIDTH)
  ) u_affine (
    .clk(clk),
    .rst_n(rst_n),
    .en(en),
    .in_vld(in_valid),
    .pt_x(in_point_x),
    .pt_y(in_point_y),
    .pt_z(in_point_z),
    .row_x(row_x_r),
    .row_y(row_y_r),
    .row_z(row_z_r),
    .out_vld(v2),
    .px(px),
    .py(py),
    .pz(pz)
  );

  // stage 3: gradient blend, parities, split squares of |px| and |pz|
  always_comb begin
    logic [CHAN_W-1:0]        a;
    logic [CHAN_W-1:0]        b;
    logic signed [CHAN_W:0]   diff;
    logic signed [2*CHAN_W+1:0] prod;
    for (int c = 0; c < 3; c++) begin
      a = col_a_r[CHAN_W*c +: CHAN_W];
      b = col_b_r[CHAN_W*c +: CHAN_W];
      diff = $signed({1'b0, b}) - $signed({1'b0, a});
      prod = diff * $signed({1'b0, px[CHAN_W-1:0]});
      side3_nxt.grad[CHAN_W*c +: CHAN_W] = a + prod[2*CHAN_W-1:CHAN_W];
    end
    side3_nxt.stripe_odd = px[PB];
    side3_nxt.checker_odd = px[PB] ^ py[PB] ^ pz[PB];
  end

  always_ff @(posedge clk) begin
    logic [CW-1:0] mx;
    logic [CW-1:0] mz;
    if (en) begin
      mx = px[CW-1] ? CW'(-px) : CW'(px);
      mz = pz[CW-1] ? CW'(-pz) : CW'(pz);
      llx_r <= mx[H-1:0] * mx[H-1:0];
      lhx_r <= mx[H-1:0] * mx[CW-1:H];
      hhx_r <= mx[CW-1:H] * mx[CW-1:H];
      llz_r <= mz[H-1:0] * mz[H-1:0];
      lhz_r <= mz[H-1:0] * mz[CW-1:H];
      hhz_r <= mz[CW-1:H] * mz[CW-1:H];
      side3_r <= side3_nxt;
    end
  end

  // stage 4 and 5: assemble squares, then sum and take the integer part
  always_ff @(posedge clk) begin
    logic [SPW-1:0] sum;
    if (en) begin
      sqx_r <= (SPW'(hhx_r) << (2 * H)) + (SPW'(lhx_r) << (H + 1)) + SPW'(llx_r);
      sqz_r <= (SPW'(hhz_r) << (2 * H)) + (SPW'(lhz_r) << (H + 1)) + SPW'(llz_r);
      sum = sqx_r + sqz_r;
      d5_r <= sum[SPW-1:32];
      side_r[0] <= side3_r;
      for (int i = 1; i < NST + 2; i++) side_r[i] <= side_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  pps_isqrt #(
    .DW(DW),
    .ITERS(PPS_SQRT_ITERS)
  ) u_isqrt (
    .clk(clk),
    .rst_n(rst_n),
    .en(en),
    .in_vld(v5_r),
    .din(d5_r),
    .out_vld(sq_vld),
    .root_odd(sq_odd)
  );

  always_comb begin
    case (mode_r)
      MODE_STRIPE:  odd = side_r[NST+1].stripe_odd;
      MODE_RING:    odd = sq_odd;
      MODE_CHECKER: odd = side_r[NST+1].checker_odd;
      default:      odd = 1'b0;
    endcase
    if (mode_r == MODE_GRADIENT) col_nxt = side_r[NST+1].grad;
    else if (odd) col_nxt = col_b_r;
    else col_nxt = col_a_r;
  end

  always_ff @(posedge clk) begin
    if (en) out_col_r <= col_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= sq_vld;
  end

  assign out_valid = out_valid_r;
  assign out_red = out_col_r[0 +: CHAN_W];
  assign out_green = out_col_r[CHAN_W +: CHAN_W];
  assign out_blue = out_col_r[2*CHAN_W +: CHAN_W];

  a_freeze_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(sq_vld))
    else $error("isqrt pipeline moved during stall");

  a_s3_to_s4: assert property (@(posedge clk) disable iff (!rst_n)
    en && v3_r |=> v4_r)
    else $error("item lost between stage 3 and 4");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    en && !sq_vld |=> !out_valid_r)
    else $error("result invented at output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(out_col_r) && $stable(side_r[NST+1]))
    else $error("pipeline state changed while output stalled");

endmodule

/* rtl/pps_affine.sv */
module pps_affine
  import pps_pkg::*;
#(
  parameter int COORD_WIDTH = PPS_COORD_WIDTH,
  parameter int MATRIX_ENTRY_WIDTH = PPS_MATRIX_ENTRY_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic signed [31:0]            pt_x,
  input  logic signed [31:0]            pt_y,
  input  logic signed [31:0]            pt_z,
  input  logic [CFG_DATA_W-1:0]         row_x,
  input  logic [CFG_DATA_W-1:0]         row_y,
  input  logic [CFG_DATA_W-1:0]         row_z,
  output logic                          out_vld,
  output logic signed [COORD_WIDTH-1:0] px,
  output logic signed [COORD_WIDTH-1:0] py,
  output logic signed [COORD_WIDTH-1:0] pz
);

  localparam int MEW = MATRIX_ENTRY_WIDTH;
  localparam int CW = COORD_WIDTH;
  localparam int PW = MEW + 32;
  localparam int AW = PW + 2;
  localparam int VW = AW - 8;
  localparam int WW = ((VW > CW) ? VW : CW) + 1;
  localparam logic signed [WW-1:0] HI = (WW'(1) <<< (CW - 1)) - WW'(1);
  localparam logic signed [WW-1:0] LO = -HI - WW'(1);

  logic [CFG_DATA_W-1:0] rows [3];
  logic signed [PW-1:0]  prod_r [3][3];
  logic signed [MEW-1:0] tr_r [3];
  logic                  v1_r;
  logic signed [CW-1:0]  coord_nxt [3];
  logic signed [CW-1:0]  coord_r [3];
  logic                  v2_r;

  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_z;

  // stage 1: nine entry by coordinate products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prod_r[r][0] <= $signed(rows[r][0 +: MEW]) * pt_x;
        prod_r[r][1] <= $signed(rows[r][16 +: MEW]) * pt_y;
        prod_r[r][2] <= $signed(rows[r][32 +: MEW]) * pt_z;
        tr_r[r] <= $signed(rows[r][48 +: MEW]);
      end
    end
  end

  // stage 2: sum, floor to q16.16, saturate
  always_comb begin
    logic signed [AW-1:0] acc;
    logic signed [WW-1:0] v;
    for (int r = 0; r < 3; r++) begin
      acc = AW'(prod_r[r][0]) + AW'(prod_r[r][1]) + AW'(prod_r[r][2])
          + (AW'(tr_r[r]) <<< 16);
      v = WW'($signed(acc[AW-1:8]));
      if (v > HI) v = HI;
      else if (v < LO) v = LO;
      coord_nxt[r] = v[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) coord_r[r] <= coord_nxt[r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  assign out_vld = v2_r;
  assign px = coord_r[0];
  assign py = coord_r[1];
  assign pz = coord_r[2];

endmodule

/* rtl/pps_isqrt.sv */
module pps_isqrt
  import pps_pkg::*;
#(
  parameter int DW = 32,
  parameter int ITERS = PPS_SQRT_ITERS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [DW-1:0] din,
  output logic          out_vld,
  output logic          root_odd
);

  localparam int RW = DW / 2;
  localparam int NST = (RW + ITERS - 1) / ITERS;

  logic [RW+1:0] rem_nxt [NST];
  logic [RW-1:0] root_nxt [NST];
  logic [DW-1:0] d_nxt [NST];
  logic [RW+1:0] rem_r [NST];
  logic [RW-1:0] root_r [NST];
  logic [DW-1:0] d_r [NST];
  logic [NST-1:0] vld_r;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    always_comb begin
      logic [RW+1:0] rm;
      logic [RW-1:0] rt;
      logic [DW-1:0] dd;
      logic [RW+1:0] trial;
      if (s == 0) begin
        rm = '0;
        rt = '0;
        dd = din;
      end else begin
        rm = rem_r[(s == 0) ? 0 : s - 1];
        rt = root_r[(s == 0) ? 0 : s - 1];
        dd = d_r[(s == 0) ? 0 : s - 1];
      end
      for (int j = 0; j < ITERS; j++) begin
        if (s * ITERS + j < RW) begin
          rm = {rm[RW-1:0], dd[DW-1:DW-2]};
          dd = dd << 2;
          trial = {rt, 2'b01};
          if (rm >= trial) begin
            rm = rm - trial;
            rt = RW'({rt, 1'b1});
          end else begin
            rt = RW'({rt, 1'b0});
          end
        end
      end
      rem_nxt[s] = rm;
      root_nxt[s] = rt;
      d_nxt[s] = dd;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
        d_r[s] <= d_nxt[s];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= (s == 0) ? in_vld : vld_r[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign out_vld = vld_r[NST-1];
  assign root_odd = root_r[NST-1][0];

endmodule
